### hw/rtl/pnos_pkg.sv
package pnos_pkg;

   localparam int TABLE_SIZE          = 256;
   localparam int FRAC_BITS           = 16;
   localparam int DEFAULT_MAX_OCTAVES = 8;
   localparam int CSR_W               = 16;
   localparam int ONE_FX              = 1 << FRAC_BITS;

   typedef enum logic [1:0] {
      CSR_Z_LAYER       = 2'd0,
      CSR_REPEAT_PERIOD = 2'd1,
      CSR_OCTAVE_COUNT  = 2'd2,
      CSR_PERSISTENCE   = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EVAL = 1'b1
   } command_type;

   localparam logic [7:0]  Z_LAYER_RST     = 8'd0;
   localparam logic [8:0]  PERIOD_RST      = 9'd0;
   localparam logic [3:0]  OCTAVE_RST      = 4'd1;
   localparam logic [15:0] PERSISTENCE_RST = 16'd32768;

   // cube-edge gradient with the z component zero
   function automatic logic signed [19:0] grad_fn(input logic [3:0] h,
                                                  input logic signed [19:0] dx,
                                                  input logic signed [19:0] dy);
      logic signed [19:0] g;
      case (h)
         4'd0:                      g = dx + dy;
         4'd1:                      g = dy - dx;
         4'd2:                      g = dx - dy;
         4'd3:                      g = -dx - dy;
         4'd4, 4'd6:                g = dx;
         4'd5, 4'd7:                g = -dx;
         4'd8, 4'd10:               g = dy;
         4'd9, 4'd11, 4'd13, 4'd15: g = -dy;
         4'd12:                     g = dy + dx;
         default:                   g = dy - dx;
      endcase
      return g;
   endfunction

endpackage

### hw/rtl/perlin_noise_octave_sum.sv
// load: no response word
// evaluate: each octave runs a remainder phase, a table read phase and a multiply phase,
//   followed by a restoring divide, after which the block returns to idle
// one evaluation at a time; busy is high until the response word is strobed
// synchronous active-high reset clears control and config; the table is not cleared
module perlin_noise_octave_sum #(
   parameter int MAX_OCTAVES = pnos_pkg::DEFAULT_MAX_OCTAVES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_command,
   input  logic [7:0]                 req_table_index,
   input  logic [7:0]                 req_table_value,
   input  logic [31:0]                req_x_coord,
   input  logic [31:0]                req_y_coord,
   output logic                       rsp_valid,
   output logic [15:0]                rsp_noise_value,
   input  logic                       csr_wr_en,
   input  logic [1:0]                 csr_index,
   input  logic [pnos_pkg::CSR_W-1:0] csr_wdata
);
   import pnos_pkg::*;

   localparam int OCT_LOG = $clog2(MAX_OCTAVES);
   localparam int AS_W    = 17 + OCT_LOG;
   localparam int TOT_W   = 34 + OCT_LOG;
   localparam int STEP_W  = $clog2(TOT_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_HASH,
      ST_MATH,
      ST_DIV
   } state_type;

   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [3:0]  oct_ff, oct_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] x_ff, x_in, y_ff, y_in;
   logic [8:0]  rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   logic [7:0]  h_ff [4];
   logic [7:0]  h_in [4];
   logic [15:0] t2_ff, t2_in;
   logic [16:0] u_ff, u_in, v_ff, v_in;
   logic signed [19:0] l1_ff, l1_in, l2_ff, l2_in;
   logic [17:0] val_ff, val_in;
   logic signed [39:0] prod_ff, prod_in;
   logic [16:0] amp_ff, amp_in;
   logic [AS_W-1:0]  amp_sum_ff, amp_sum_in, rem_ff, rem_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic [7:0]  z_ff;
   logic [8:0]  period_ff;
   logic [3:0]  octs_ff;
   logic [15:0] pers_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_value_ff, rsp_value_in;

   logic [7:0] perm_mem [TABLE_SIZE];
   logic [7:0] rdata_ff;
   logic       mem_we, mem_re;
   logic [7:0] mem_raddr;

   logic               accept;
   logic [31:0]        xs, ys;
   logic [15:0]        xint, yint, zext;
   logic [3:0]         bidx;
   logic [9:0]         rx2, ry2, rz2, p10;
   logic [7:0]         xi, xn, yi, yn, zi, cx, cy;
   logic [1:0]         corner;
   logic signed [19:0] xf, yf, xf1, yf1;
   logic signed [19:0] g00, g10, g01, g11, d0, d1, nval, sval;
   logic [21:0]        inner;
   logic signed [17:0] mul_a;
   logic signed [21:0] mul_b;
   logic [AS_W:0]      rem2;
   logic [4:0]         cnt_req;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         perm_mem[req_table_index] <= req_table_value;
      end
      if (mem_re) begin
         rdata_ff <= perm_mem[mem_raddr];
      end
   end

   assign mem_we = accept && (req_command == CMD_LOAD);

   always_comb begin
      xs   = x_ff << oct_ff;
      ys   = y_ff << oct_ff;
      xint = xs[31:16];
      yint = ys[31:16];
      zext = {8'd0, z_ff};
      bidx = 4'd15 - step_ff[3:0];
      p10  = {1'b0, period_ff};
      rx2  = {rx_ff, xint[bidx]};
      ry2  = {ry_ff, yint[bidx]};
      rz2  = {rz_ff, zext[bidx]};
      if (rx2 >= p10) rx2 = rx2 - p10;
      if (ry2 >= p10) ry2 = ry2 - p10;
      if (rz2 >= p10) rz2 = rz2 - p10;

      if (period_ff == 9'd0) begin
         xi = xint[7:0];
         yi = yint[7:0];
         zi = z_ff;
         xn = xi + 8'd1;
         yn = yi + 8'd1;
      end else begin
         xi = rx_ff[7:0];
         yi = ry_ff[7:0];
         zi = rz_ff[7:0];
         xn = (({1'b0, xi} + 9'd1) == period_ff) ? 8'd0 : xi + 8'd1;
         yn = (({1'b0, yi} + 9'd1) == period_ff) ? 8'd0 : yi + 8'd1;
      end

      corner = step_ff[1:0];
      cx = corner[0] ? xn : xi;
      cy = corner[1] ? yn : yi;
      case (step_ff[3:2])
         2'd0:    mem_raddr = cx;
         2'd1:    mem_raddr = h_ff[corner] + cy;
         default: mem_raddr = h_ff[corner] + zi;
      endcase
      mem_re = (state_ff == ST_HASH) && (step_ff < STEP_W'(12));

      xf  = $signed({4'd0, xs[15:0]});
      yf  = $signed({4'd0, ys[15:0]});
      xf1 = xf - 20'(ONE_FX);
      yf1 = yf - 20'(ONE_FX);
      g00 = grad_fn(h_ff[0][3:0], xf, yf);
      g10 = grad_fn(h_ff[1][3:0], xf1, yf);
      g01 = grad_fn(h_ff[2][3:0], xf, yf1);
      g11 = grad_fn(h_ff[3][3:0], xf1, yf1);
      d0  = g10 - g00;
      d1  = g11 - g01;
      nval = l1_ff + prod_ff[35:16];
      sval = nval + 20'(ONE_FX);
      inner = 22'(t2_ff) * 22'd6 + 22'(10 * ONE_FX)
            - 22'((step_ff == STEP_W'(2)) ? xs[15:0] : ys[15:0]) * 22'd15;

      mul_a = '0;
      mul_b = '0;
      case (step_ff[3:0])
         4'd0:  begin mul_a = 18'(xf); mul_b = 22'(xf); end
         4'd1:  begin mul_a = $signed({2'd0, prod_ff[31:16]}); mul_b = 22'(xf); end
         4'd2:  begin mul_a = $signed({2'd0, prod_ff[31:16]}); mul_b = $signed(inner); end
         4'd3:  begin mul_a = 18'(yf); mul_b = 22'(yf); end
         4'd4:  begin mul_a = $signed({2'd0, prod_ff[31:16]}); mul_b = 22'(yf); end
         4'd5:  begin mul_a = $signed({2'd0, prod_ff[31:16]}); mul_b = $signed(inner); end
         4'd6:  begin mul_a = $signed({1'b0, u_ff}); mul_b = 22'(d0); end
         4'd7:  begin mul_a = $signed({1'b0, u_ff}); mul_b = 22'(d1); end
         4'd9:  begin mul_a = $signed({1'b0, v_ff}); mul_b = 22'(l2_ff - l1_ff); end
         4'd11: begin mul_a = $signed(val_ff); mul_b = $signed({5'd0, amp_ff}); end
         4'd12: begin mul_a = $signed({1'b0, amp_ff}); mul_b = $signed({6'd0, pers_ff}); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      prod_in = mul_a * mul_b;

      rem2 = {rem_ff, total_ff[TOT_W-1]};

      if (octs_ff == 4'd0) begin
         cnt_req = 5'd1;
      end else if ({1'b0, octs_ff} > 5'(MAX_OCTAVES)) begin
         cnt_req = 5'(MAX_OCTAVES);
      end else begin
         cnt_req = {1'b0, octs_ff};
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff + STEP_W'(1);
      oct_in       = oct_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      rz_in        = rz_ff;
      h_in         = h_ff;
      t2_in        = t2_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      l1_in        = l1_ff;
      l2_in        = l2_ff;
      val_in       = val_ff;
      amp_in       = amp_ff;
      amp_sum_in   = amp_sum_ff;
      rem_in       = rem_ff;
      total_in     = total_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;

      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept && (req_command == CMD_EVAL)) begin
               state_in   = ST_MOD;
               x_in       = req_x_coord;
               y_in       = req_y_coord;
               cnt_in     = cnt_req;
               oct_in     = 4'd0;
               amp_in     = 17'(ONE_FX);
               amp_sum_in = '0;
               total_in   = '0;
               rx_in      = '0;
               ry_in      = '0;
               rz_in      = '0;
            end
         end
         ST_MOD: begin
            rx_in = rx2[8:0];
            ry_in = ry2[8:0];
            rz_in = rz2[8:0];
            if (step_ff == STEP_W'(15)) begin
               state_in = ST_HASH;
               step_in  = '0;
            end
         end
         ST_HASH: begin
            if (step_ff != '0) begin
               h_in[2'(step_ff - STEP_W'(1))] = rdata_ff;
            end
            if (step_ff == STEP_W'(12)) begin
               state_in = ST_MATH;
               step_in  = '0;
            end
         end
         ST_MATH: begin
            case (step_ff[3:0])
               4'd1, 4'd4: t2_in = prod_ff[31:16];
               4'd3:  u_in  = prod_ff[32:16];
               4'd6:  v_in  = prod_ff[32:16];
               4'd7:  l1_in = g00 + prod_ff[35:16];
               4'd8:  l2_in = g01 + prod_ff[35:16];
               4'd10: val_in = (sval <= 0) ? 18'd0 : {1'b0, sval[17:1]};
               4'd12: begin
                  total_in   = total_ff + TOT_W'(prod_ff[33:0]);
                  amp_sum_in = amp_sum_ff + AS_W'(amp_ff);
               end
               4'd13: begin
                  amp_in  = prod_ff[32:16];
                  step_in = '0;
                  rx_in   = '0;
                  ry_in   = '0;
                  rz_in   = '0;
                  rem_in  = '0;
                  if ({1'b0, oct_ff} + 5'd1 == cnt_ff) begin
                     state_in = ST_DIV;
                  end else begin
                     oct_in   = oct_ff + 4'd1;
                     state_in = ST_MOD;
                  end
               end
               default: ;
            endcase
            if (step_ff == STEP_W'(7)) begin
               l1_in = g00 + prod_ff[35:16];
            end
            if (step_ff == STEP_W'(10)) begin
               l1_in = nval;
            end
         end
         ST_DIV: begin
            if (step_ff == STEP_W'(TOT_W)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_value_in = (|total_ff[TOT_W-1:16]) ? 16'hFFFF : total_ff[15:0];
            end else if (rem2 >= {1'b0, amp_sum_ff}) begin
               rem_in   = AS_W'(rem2 - {1'b0, amp_sum_ff});
               total_in = {total_ff[TOT_W-2:0], 1'b1};
            end else begin
               rem_in   = rem2[AS_W-1:0];
               total_in = {total_ff[TOT_W-2:0], 1'b0};
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         z_ff         <= Z_LAYER_RST;
         period_ff    <= PERIOD_RST;
         octs_ff      <= OCTAVE_RST;
         pers_ff      <= PERSISTENCE_RST;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_Z_LAYER:       z_ff      <= csr_wdata[7:0];
               CSR_REPEAT_PERIOD: period_ff <= csr_wdata[8:0];
               CSR_OCTAVE_COUNT:  octs_ff   <= csr_wdata[3:0];
               CSR_PERSISTENCE:   pers_ff   <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      oct_ff       <= oct_in;
      cnt_ff       <= cnt_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      rz_ff        <= rz_in;
      h_ff         <= h_in;
      t2_ff        <= t2_in;
      u_ff         <= u_in;
      v_ff         <= v_in;
      l1_ff        <= l1_in;
      l2_ff        <= l2_in;
      val_ff       <= val_in;
      prod_ff      <= prod_in;
      amp_ff       <= amp_in;
      amp_sum_ff   <= amp_sum_in;
      rem_ff       <= rem_in;
      total_ff     <= total_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

### hw/rtl/pnos_checker.sv
module pnos_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_command,
   input logic rsp_valid
);
   import pnos_pkg::*;

   // evaluate word starts work
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command == CMD_EVAL |=> busy)
      else $error("evaluate not taken");

   // load word gives no response
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command == CMD_LOAD |=> !busy && !rsp_valid)
      else $error("load produced response");

   // response ends the work
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("repeated response");

   a_reset: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind perlin_noise_octave_sum pnos_checker u_pnos_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_command (req_command),
   .rsp_valid   (rsp_valid)
);
